// File: rtl/dqp_pkg.sv
package dqp_pkg;

    localparam int CHAR_W    = 8;
    localparam int OCTET_W   = 8;
    localparam int ADDR_W    = 32;
    localparam int HIGH_W    = 24;
    localparam int PART_W    = 2;
    // digit accumulate: 255 * 10 + 9 fits in 12 bits
    localparam int ACC_W     = 12;

    localparam logic [CHAR_W-1:0]  CHAR_DOT  = 8'h2E;
    localparam logic [CHAR_W-1:0]  CHAR_ZERO = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_NINE = 8'h39;
    localparam logic [CHAR_W-1:0]  CHAR_NUL  = 8'h00;
    localparam logic [CHAR_W-1:0]  CHAR_TAB  = 8'h09;
    localparam logic [CHAR_W-1:0]  CHAR_CR   = 8'h0D;
    localparam logic [CHAR_W-1:0]  CHAR_SPC  = 8'h20;
    localparam logic [ACC_W-1:0]   OCTET_MAX = 12'd255;
    localparam logic [PART_W-1:0]  LAST_PART = 2'd3;

    function automatic logic is_space_code(input logic [CHAR_W-1:0] c);
        return ((c >= CHAR_TAB) && (c <= CHAR_CR)) || (c == CHAR_SPC);
    endfunction

endpackage

// File: rtl/dotted_quad_ipv4_parser_unit.sv
// Streaming dotted-quad IPv4 parser: one character per input transaction, one transaction
// per cycle sustained. Each character is captured in an input register, then one short pass
// (decimal accumulate of the current part, range and separator checks) updates the parse
// state and, at the deciding character, loads the result register. A result that waits
// on out_ready stalls the input register only if the next character would also give a
// result. Set starts_text on the first character of each string; characters after the
// decision give nothing until the next start. address is zero whenever accepted is low.
module dotted_quad_ipv4_parser_unit
    import dqp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [CHAR_W-1:0] character,
    input  logic              starts_text,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              accepted,
    output logic [ADDR_W-1:0] address
);

    logic              s1_valid_reg;
    logic [CHAR_W-1:0] char_reg;
    logic              start_reg;

    logic [PART_W-1:0]  part_reg,     part_next;
    logic               awaiting_reg, awaiting_next;
    logic [OCTET_W-1:0] octet_reg,    octet_next;
    logic [HIGH_W-1:0]  high_reg,     high_next;
    logic               decided_reg,  decided_next;

    logic              out_valid_reg;
    logic              accepted_reg, accepted_next;
    logic [ADDR_W-1:0] address_reg,  address_next;

    // effective state after an optional start clear
    logic [PART_W-1:0]  cur_part;
    logic               cur_awaiting;
    logic [OCTET_W-1:0] cur_octet;
    logic [HIGH_W-1:0]  cur_high;
    logic               cur_decided;

    logic             is_digit;
    logic [ACC_W-1:0] acc;
    logic             produce;
    logic             out_free;
    logic             s1_fire;

    always_comb
    begin
        cur_part     = start_reg ? '0 : part_reg;
        cur_awaiting = start_reg ? 1'b1 : awaiting_reg;
        cur_octet    = start_reg ? '0 : octet_reg;
        cur_high     = start_reg ? '0 : high_reg;
        cur_decided  = start_reg ? 1'b0 : decided_reg;

        is_digit = (char_reg >= CHAR_ZERO) && (char_reg <= CHAR_NINE);
        acc = ({{(ACC_W-OCTET_W){1'b0}}, cur_octet} << 3)
            + ({{(ACC_W-OCTET_W){1'b0}}, cur_octet} << 1)
            + {{(ACC_W-CHAR_W){1'b0}}, char_reg - CHAR_ZERO};

        part_next     = cur_part;
        awaiting_next = cur_awaiting;
        octet_next    = cur_octet;
        high_next     = cur_high;
        decided_next  = cur_decided;
        produce       = 1'b0;
        accepted_next = 1'b0;
        address_next  = '0;

        if (!cur_decided)
        begin
            if (is_digit)
            begin
                if (acc > OCTET_MAX)
                begin
                    produce = 1'b1;
                end
                else
                begin
                    octet_next    = acc[OCTET_W-1:0];
                    awaiting_next = 1'b0;
                end
            end
            else if (cur_awaiting)
            begin
                produce = 1'b1;
            end
            else if (cur_part != LAST_PART)
            begin
                if (char_reg != CHAR_DOT)
                begin
                    produce = 1'b1;
                end
                else
                begin
                    high_next     = {cur_high[HIGH_W-OCTET_W-1:0], cur_octet};
                    part_next     = cur_part + 1'b1;
                    octet_next    = '0;
                    awaiting_next = 1'b1;
                end
            end
            else
            begin
                produce = 1'b1;
                if ((char_reg == CHAR_NUL) || is_space_code(char_reg))
                begin
                    accepted_next = 1'b1;
                    address_next  = {cur_high, cur_octet};
                end
            end
        end
        if (produce)
        begin
            decided_next = 1'b1;
        end
    end

    assign out_free = !out_valid_reg || out_ready;
    assign s1_fire  = s1_valid_reg && (out_free || !produce);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            part_reg      <= '0;
            awaiting_reg  <= 1'b1;
            octet_reg     <= '0;
            high_reg      <= '0;
            decided_reg   <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_fire)
            begin
                part_reg     <= part_next;
                awaiting_reg <= awaiting_next;
                octet_reg    <= octet_next;
                high_reg     <= high_next;
                decided_reg  <= decided_next;
            end
            if (s1_fire && produce)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            char_reg  <= character;
            start_reg <= starts_text;
        end
        if (s1_fire && produce)
        begin
            accepted_reg <= accepted_next;
            address_reg  <= address_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign accepted  = accepted_reg;
    assign address   = address_reg;

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !accepted_reg |-> address_reg == '0)
        else $error("rejected result carries nonzero address");

    a_decided_after_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && produce |=> decided_reg && out_valid_reg)
        else $error("result transaction did not set decided state");

    a_awaiting_octet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> octet_reg == '0)
        else $error("octet accumulator nonzero while waiting for first digit");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> s1_valid_reg && out_valid_reg && !out_ready)
        else $error("input stalled without a blocked result");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dqp_pkg::*;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              first;
    } text_byte_t;

    typedef struct {
        logic              ok;
        logic [ADDR_W-1:0] addr;
    } verdict_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [CHAR_W-1:0] character = '0;
    logic              starts_text = 1'b0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic              accepted;
    logic [ADDR_W-1:0] address;

    text_byte_t text_queue[$];
    verdict_t   verdict_queue[$];
    int         fail_count = 0;
    int         chars_sent = 0;
    int         verdicts_seen = 0;
    int         send_wait = 0;
    int         recv_wait = 0;
    int         hold_left = 0;

    // parser state as the predictor sees it
    logic [PART_W-1:0]  cur_part = '0;
    logic               need_digit = 1'b1;
    logic [OCTET_W-1:0] part_value = '0;
    logic [HIGH_W-1:0]  done_octets = '0;
    logic               text_decided = 1'b0;

    dotted_quad_ipv4_parser_unit i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .character   (character),
        .starts_text (starts_text),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .accepted    (accepted),
        .address     (address)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic record_verdict(input logic ok, input logic [ADDR_W-1:0] addr);
        verdict_t v;
        v.ok = ok;
        v.addr = ok ? addr : '0;
        verdict_queue.push_back(v);
        text_decided = 1'b1;
    endtask

    task automatic parse_char(input logic [CHAR_W-1:0] ch, input logic first);
        int unsigned acc;
        if (first)
        begin
            cur_part = '0;
            need_digit = 1'b1;
            part_value = '0;
            done_octets = '0;
            text_decided = 1'b0;
        end
        if (!text_decided)
        begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
            begin
                acc = part_value * 10 + (ch - CHAR_ZERO);
                if (acc > OCTET_MAX)
                    record_verdict(1'b0, '0);
                else
                begin
                    part_value = acc[OCTET_W-1:0];
                    need_digit = 1'b0;
                end
            end
            else if (need_digit)
                record_verdict(1'b0, '0);
            else if (cur_part != LAST_PART)
            begin
                if (ch != CHAR_DOT)
                    record_verdict(1'b0, '0);
                else
                begin
                    done_octets = {done_octets[HIGH_W-OCTET_W-1:0], part_value};
                    cur_part = cur_part + 1'b1;
                    part_value = '0;
                    need_digit = 1'b1;
                end
            end
            else if (ch == CHAR_NUL || ch == CHAR_SPC || (ch >= CHAR_TAB && ch <= CHAR_CR))
                record_verdict(1'b1, {done_octets, part_value});
            else
                record_verdict(1'b0, '0);
        end
    endtask

    task automatic push_byte(input logic [CHAR_W-1:0] ch, input logic first);
        text_byte_t b;
        b.ch = ch;
        b.first = first;
        text_queue.push_back(b);
    endtask

    task automatic push_text(input string s, input logic first);
        for (int i = 0; i < s.len(); i++)
            push_byte(s[i], first && i == 0);
    endtask

    task automatic add_random_text();
        logic [CHAR_W-1:0] txt[$];
        string             num;
        int                kind;
        int                val;
        int                pos;
        int                pick;
        kind = $urandom_range(0, 11);
        if (kind == 11)
        begin
            // raw noise over the whole byte range
            repeat ($urandom_range(1, 6))
                txt.push_back(CHAR_W'($urandom_range(0, 255)));
        end
        else
        begin
            pos = $urandom_range(0, 3);
            for (int p = 0; p < 4; p++)
            begin
                if (p > 0)
                    txt.push_back(CHAR_DOT);
                case ($urandom_range(0, 7))
                    0: val = 0;
                    1: val = 255;
                    2: val = $urandom_range(0, 9);
                    default: val = $urandom_range(0, 255);
                endcase
                if (kind == 7 && p == pos)
                    val = $urandom_range(256, 999);
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 2))
                        txt.push_back(CHAR_ZERO);
                num = $sformatf("%0d", val);
                for (int i = 0; i < num.len(); i++)
                    txt.push_back(num[i]);
            end
            pick = $urandom_range(0, 6);
            txt.push_back(pick == 6 ? CHAR_NUL : pick == 5 ? CHAR_SPC
                                               : CHAR_W'(CHAR_TAB + pick));
            case (kind)
                8: txt[$urandom_range(0, txt.size() - 1)] = CHAR_W'($urandom_range(0, 255));
                9: txt.insert($urandom_range(0, txt.size() - 1),
                              CHAR_W'($urandom_range(0, 255)));
                10:
                begin
                    pos = $urandom_range(0, txt.size() - 1);
                    while (txt.size() > pos)
                        void'(txt.pop_back());
                end
                default: ;
            endcase
            // trailing bytes after the decision are ignored by the parser
            repeat ($urandom_range(0, 2))
                txt.push_back($urandom_range(0, 1) ? CHAR_W'(CHAR_ZERO + $urandom_range(0, 9))
                                                   : CHAR_W'($urandom_range(0, 255)));
        end
        for (int i = 0; i < txt.size(); i++)
            push_byte(txt[i], i == 0 ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 63) == 0));
    endtask

    // driver: one character transaction at a time from text_queue
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_char(character, starts_text);
                chars_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_wait > 0)
                begin
                    send_wait--;
                    in_valid <= 1'b0;
                end
                else if (text_queue.size() > 0)
                begin
                    in_valid <= 1'b1;
                    character <= text_queue[0].ch;
                    starts_text <= text_queue[0].first;
                    void'(text_queue.pop_front());
                    send_wait = (((chars_sent / 256) % 4) == 2) ? 0 : $urandom_range(0, 3);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor: compare each result transaction with the oldest predicted verdict
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (verdict_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 20)
                        $display("%0t: unexpected result accepted=%0b address=%h",
                                 $time, accepted, address);
                end
                else
                begin
                    if (accepted !== verdict_queue[0].ok)
                    begin
                        fail_count++;
                        if (fail_count <= 20)
                            $display("%0t: accepted expected %0b actual %0b",
                                     $time, verdict_queue[0].ok, accepted);
                    end
                    if (address !== verdict_queue[0].addr)
                    begin
                        fail_count++;
                        if (fail_count <= 20)
                            $display("%0t: address expected %h actual %h",
                                     $time, verdict_queue[0].addr, address);
                    end
                    void'(verdict_queue.pop_front());
                end
                verdicts_seen++;
                recv_wait = (((verdicts_seen / 16) % 4) == 2) ? 0 : $urandom_range(0, 3);
                // long back-pressure so the parser fills up and stalls its input
                if (verdicts_seen == 40 || verdicts_seen == 150)
                    hold_left = 300;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_wait > 0)
            begin
                recv_wait--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        // no start flag after reset: parse as if a string had begun
        push_text("0.0.0.0", 1'b0);
        push_byte(CHAR_NUL, 1'b0);
        // part above 255, then a byte after the decision
        push_text("2567", 1'b1);
        push_text(".", 1'b1);
        push_text("1x", 1'b1);
        push_byte(8'hFF, 1'b1);
        push_text("255.0.0.9", 1'b1);
        push_byte(CHAR_CR, 1'b0);
        while (text_queue.size() < 1900)
            add_random_text();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        while (text_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
            @(negedge clk);
        repeat (10) @(posedge clk);
        if (fail_count == 0 && verdict_queue.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
